// ===== src/ppi_pkg.sv =====
// Shared types, constants and trig table builder for the particle pool integrator.
`default_nettype none

package ppi_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 64;
    localparam int SLOT_W    = $clog2(POOL_SIZE);

    // Operation codes carried in the input tuser
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_EMIT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Fixed values
    localparam logic [22:0] GRAVITY_RESET = 23'd642253;
    localparam logic [31:0] SEED_INIT     = 32'h1D872B41;
    localparam logic [31:0] LFSR_MASK     = 32'h80200003;
    localparam logic [31:0] PARK_Y        = 32'd65536000;
    localparam logic [8:0]  DEG_WRAP      = 9'd360;

    // Angle constants in Q2.30
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint HALFPI_Q30 = 64'sd1686629713;
    localparam longint TWOPI_Q30  = 64'sd6746518852;

    // Stream widths
    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 136;

    // One slot of the pool as kept in the slot memory
    typedef struct packed {
        logic [31:0]      life;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [15:0]      damp;
        logic [31:0]      color;
    } t_slot;

    // Sine or cosine per whole degree, signed Q16
    typedef logic [359:0][17:0] t_trig_tab;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [50:0] v);
        logic [31:0] res;
        if (v > 51'sd2147483647) begin
            res = 32'h7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            res = 32'h80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // One step of the right-shifting Galois LFSR.
    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic [31:0] n;
        n = {1'b0, s[31:1]};
        if (s[0]) begin
            n = n ^ LFSR_MASK;
        end
        return n;
    endfunction

    // Sine of a Q2.30 angle by Taylor series, evaluated at elaboration only.
    function automatic logic [17:0] sin_q16(input longint x_in);
        longint x;
        longint sum;
        longint term;
        logic   neg;
        int     k;
        x   = x_in;
        neg = 1'b0;
        if (x >= TWOPI_Q30) begin
            x = x - TWOPI_Q30;
        end
        if (x >= TWOPI_Q30) begin
            x = x - TWOPI_Q30;
        end
        if (x >= PI_Q30) begin
            x   = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > HALFPI_Q30) begin
            x = PI_Q30 - x;
        end
        sum  = x;
        term = x;
        for (k = 1; k <= 8; k++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            case (k)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                7: term = term / 210;
                default: term = term / 272;
            endcase
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 8192) >>> 14;
        if (neg) begin
            sum = -sum;
        end
        return sum[17:0];
    endfunction

    // Degrees scaled with 3.14 as pi, into Q2.30 radians.
    function automatic longint deg_to_q30(input int deg);
        longint v;
        v = longint'(deg) * 157;
        v = (v <<< 30) / 9000;
        return v;
    endfunction

    // Whole table of sines, or of cosines when want_cos is set.
    function automatic t_trig_tab build_trig(input logic want_cos);
        t_trig_tab tab;
        int        d;
        for (d = 0; d < 360; d++) begin
            if (want_cos) begin
                tab[d] = sin_q16(deg_to_q30(d) + HALFPI_Q30);
            end else begin
                tab[d] = sin_q16(deg_to_q30(d));
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== src/ppi_mem.sv =====
// Slot memory: one entry per particle slot, one write and one registered read port.
`default_nettype none

module ppi_mem
    import ppi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [SLOT_W-1:0] i_waddr,
    input  wire t_slot             i_wdata,
    input  wire logic [SLOT_W-1:0] i_raddr,
    output t_slot                  o_rdata
);

    t_slot mem [POOL_SIZE];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/ppi_mul.sv =====
// Two-stage signed multiplier with optional Q16 rounding, ties away from zero.
`default_nettype none

module ppi_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [17:0] i_b,
    input  wire logic               i_round,
    output logic                    o_done,
    output logic signed [49:0]      o_res
);

    logic [31:0] mag_a;
    logic [16:0] mag_b;
    logic [32:0] neg_a;
    logic [17:0] neg_b;
    logic        r_v1;
    logic        r_neg;
    logic        r_rnd;
    logic [48:0] r_prod;
    logic [48:0] rounded;

    // Magnitudes of the operands
    always_comb begin
        neg_a = -i_a;
        neg_b = -i_b;
        mag_a = i_a[32] ? neg_a[31:0] : i_a[31:0];
        mag_b = i_b[17] ? neg_b[16:0] : i_b[16:0];
    end

    // First stage: unsigned product
    always_ff @(posedge i_clk) begin
        r_prod <= mag_a * mag_b;
        r_neg  <= i_a[32] ^ i_b[17];
        r_rnd  <= i_round;
    end

    // Round back to Q16.16 when asked
    always_comb begin
        rounded = r_rnd ? ((r_prod + 49'd32768) >> 16) : r_prod;
    end

    // Second stage: apply the sign
    always_ff @(posedge i_clk) begin
        o_res <= r_neg ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
    end

    // Done pulse: start delayed through r_v1, in step with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            o_done <= r_v1;
        end
    end

endmodule

`default_nettype wire

// ===== src/ppi_rem.sv =====
// Restoring remainder unit: 15-bit dividend by a 9-bit divisor, one bit a cycle.
`default_nettype none

module ppi_rem (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [14:0] i_num,
    input  wire logic [8:0]  i_den,
    output logic             o_done,
    output logic [8:0]       o_rem
);

    logic [14:0] r_num;
    logic [8:0]  r_den;
    logic [8:0]  r_rem;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [9:0]  trial;
    logic [9:0]  diff;
    logic [8:0]  n_rem;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_num[14]};
        diff  = trial - {1'b0, r_den};
        n_rem = (trial >= {1'b0, r_den}) ? diff[8:0] : trial[8:0];
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[13:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

// ===== src/particle_pool_integrator.sv =====
// Top level of the particle pool integrator: control sequencer, trig tables and stream ports.
`default_nettype none

// The block keeps 64 particle slots in a single slot memory and works on one request at a
// time. A clear request marks every slot inactive. An emit request places each particle in
// steps: a search for the lowest free slot that also draws the first angle, a draw of the
// second angle, the speed draw in the bit-serial remainder unit, five products of the
// shared two-stage multiplier and the slot write; a full pool ends the burst after the
// search. A tick request first forms the gravity term with the shared multiplier and then,
// per slot, reads the memory; a live slot then takes six products of the shared multiplier
// and a write-back, while an idle slot skips both. Each slot's result can stall on the
// result port. Inactive slots report x and z zero and y parked at 1000.0.
module particle_pool_integrator
    import ppi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [22:0]           i_cfg_wr_data,   // gravity_accel
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // delta_time, origin_x, origin_y, origin_z, tint, power, life_span, damping, burst_count
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic [1:0]            i_s_tuser,       // func
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // slot, alive, at_x, at_y, at_z, shade
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tlast        // final_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GDT   = 4'd1;
    localparam logic [3:0] S_GDTW  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_LD    = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_MULW  = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_FIND  = 4'd9;
    localparam logic [3:0] S_REMW  = 4'd10;
    localparam logic [3:0] S_EMUL  = 4'd11;
    localparam logic [3:0] S_EMULW = 4'd12;
    localparam logic [3:0] S_EWR   = 4'd13;
    localparam logic [3:0] S_DRAW  = 4'd14;

    // Reciprocal of 360 scaled by 2^22, exact for 15-bit draws
    localparam logic [13:0] RECIP_360 = 14'd11651;

    localparam t_trig_tab SIN_TAB = build_trig(1'b0);
    localparam t_trig_tab COS_TAB = build_trig(1'b1);

    // Draw reduced to whole degrees by reciprocal multiplication.
    function automatic logic [8:0] mod360(input logic [14:0] r);
        logic [28:0] prod;
        logic [6:0]  q;
        logic [15:0] qm;
        logic [14:0] diff;
        prod = {14'd0, r} * {15'd0, RECIP_360};
        q    = prod[28:22];
        qm   = {9'd0, q} * {7'd0, DEG_WRAP};
        diff = r - qm[14:0];
        return diff[8:0];
    endfunction

    logic [3:0]           r_state;
    logic [22:0]          r_gravity;
    logic [31:0]          r_seed;
    logic [POOL_SIZE-1:0] r_active;
    logic [SLOT_W-1:0]    r_slot;
    logic [2:0]           r_k;
    logic [6:0]           r_left;
    logic                 r_alive;
    t_slot                r_ent;
    logic [15:0]          r_dt;
    logic [23:0]          r_gdt;

    // Burst parameters held for the whole emit
    logic [2:0][31:0]     r_org;
    logic [31:0]          r_tint;
    logic [8:0]           r_power;
    logic [30:0]          r_span;
    logic [15:0]          r_damp;

    // Random angles, speed and trig values
    logic [8:0]           r_a1;
    logic [8:0]           r_a2;
    logic [7:0]           r_speed;
    logic [17:0]          r_s1;
    logic [17:0]          r_c1;
    logic [17:0]          r_s2;
    logic [17:0]          r_c2;
    logic signed [32:0]   r_t;
    logic [2:0][31:0]     r_vel;

    // Output register
    logic                 r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                 r_m_last;

    // Unit hookups
    logic                 mul_start;
    logic signed [32:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic                 mul_rnd;
    logic                 mul_done;
    logic signed [49:0]   mul_res;
    logic signed [50:0]   mul_wide;
    logic                 rem_start;
    logic [14:0]          rem_num;
    logic [8:0]           rem_den;
    logic                 rem_done;
    logic [8:0]           rem_out;
    logic                 mem_we;
    t_slot                mem_wdata;
    t_slot                mem_rdata;
    logic [SLOT_W-1:0]    mem_raddr;

    logic [31:0]          seed_next;
    logic [8:0]           draw_deg;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_slot;
    logic [1:0]           j_idx;
    logic                 out_free;
    logic signed [50:0]   pos_sum;
    logic signed [50:0]   vy_grav;
    logic [31:0]          life_dec;
    logic [8:0]           spd_sum;
    t_slot                ld_ent;
    logic [OUT_DATA_W-1:0] out_word;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign out_free   = !r_m_valid || i_m_tready;
    assign seed_next  = lfsr_next(r_seed);
    assign draw_deg   = mod360(seed_next[14:0]);
    assign j_idx      = r_k[2:1];
    assign mul_wide   = {mul_res[49], mul_res};
    assign mem_raddr  = r_slot;
    assign spd_sum    = rem_out + 9'd1;

    // Lowest inactive slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Trig table reads, registered
    always_ff @(posedge i_clk) begin
        r_s1 <= SIN_TAB[r_a1];
        r_c1 <= COS_TAB[r_a1];
        r_s2 <= SIN_TAB[r_a2];
        r_c2 <= COS_TAB[r_a2];
    end

    // Multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_rnd   = 1'b1;
        case (r_state)
            S_GDT: begin
                mul_start = 1'b1;
                mul_a     = {10'd0, r_gravity};
                mul_b     = {2'd0, r_dt};
            end
            S_MUL: begin
                mul_start = 1'b1;
                mul_a     = {r_ent.vel[j_idx][31], r_ent.vel[j_idx]};
                mul_b     = r_k[0] ? {2'd0, r_ent.damp} : {2'd0, r_dt};
            end
            S_EMUL: begin
                mul_start = 1'b1;
                case (r_k)
                    3'd0: begin
                        mul_a   = {25'd0, r_speed};
                        mul_b   = r_c1;
                        mul_rnd = 1'b0;
                    end
                    3'd2: begin
                        mul_a   = {25'd0, r_speed};
                        mul_b   = r_s1;
                        mul_rnd = 1'b0;
                    end
                    3'd4: begin
                        mul_a   = {25'd0, r_speed};
                        mul_b   = r_c2;
                        mul_rnd = 1'b0;
                    end
                    default: begin
                        mul_a = r_t;
                        mul_b = r_s2;
                    end
                endcase
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Tick arithmetic on the slot just read
    always_comb begin
        life_dec = mem_rdata.life - {16'd0, r_dt};
        vy_grav  = $signed({{19{mem_rdata.vel[1][31]}}, mem_rdata.vel[1]})
                 - $signed({27'd0, r_gdt});
        pos_sum  = $signed({{19{r_ent.pos[j_idx][31]}}, r_ent.pos[j_idx]}) + mul_wide;
    end

    // Slot as loaded: life lost and gravity applied
    always_comb begin
        ld_ent        = mem_rdata;
        ld_ent.life   = life_dec;
        ld_ent.vel[1] = sat32(vy_grav);
    end

    // Result word for the current slot
    always_comb begin
        if (r_alive) begin
            out_word = {1'b0, r_ent.color, r_ent.pos[2], r_ent.pos[1], r_ent.pos[0],
                        r_alive, r_slot};
        end else begin
            out_word = {1'b0, 32'd0, 32'd0, PARK_Y, 32'd0, r_alive, r_slot};
        end
    end

    // Memory write selection: emit placement or tick write-back
    always_comb begin
        mem_we    = (r_state == S_WB) || (r_state == S_EWR);
        mem_wdata = r_ent;
        if (r_state == S_EWR) begin
            mem_wdata.life  = {1'b0, r_span};
            mem_wdata.pos   = r_org;
            mem_wdata.vel   = r_vel;
            mem_wdata.damp  = r_damp;
            mem_wdata.color = r_tint;
        end
    end

    // The speed draw goes through the remainder unit
    always_comb begin
        rem_start = (r_state == S_DRAW) && (r_k == 3'd1);
        rem_num   = seed_next[14:0];
        rem_den   = r_power;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (i_cfg_wr_en) begin
            r_gravity <= i_cfg_wr_data;
        end
    end

    // Result valid: set when a result is loaded, cleared when it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_seed    <= SEED_INIT;
            r_slot    <= '0;
            r_k       <= '0;
            r_left    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        case (i_s_tuser)
                            FUNC_TICK: begin
                                r_slot  <= '0;
                                r_state <= S_GDT;
                            end
                            FUNC_EMIT: begin
                                r_left <= i_s_tdata[205:199];
                                if (i_s_tdata[205:199] != 7'd0) begin
                                    r_state <= S_FIND;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_active <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_GDT: begin
                    r_state <= S_GDTW;
                end
                S_GDTW: begin
                    if (mul_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    if (r_active[r_slot] && !mem_rdata.life[31] && mem_rdata.life != 32'd0) begin
                        r_k     <= '0;
                        r_alive <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_active[r_slot] <= 1'b0;
                        r_alive          <= 1'b0;
                        r_state          <= S_OUT;
                    end
                end
                S_MUL: begin
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    if (mul_done) begin
                        if (r_k == 3'd5) begin
                            r_state <= S_WB;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_WB: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_slot <= r_slot + SLOT_W'(1);
                        if (r_slot == SLOT_W'(POOL_SIZE - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIND: begin
                    if (free_found) begin
                        r_slot  <= free_slot;
                        r_seed  <= seed_next;
                        r_k     <= '0;
                        r_state <= S_DRAW;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DRAW: begin
                    r_seed <= seed_next;
                    if (r_k == 3'd1) begin
                        r_k     <= '0;
                        r_state <= S_REMW;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_REMW: begin
                    if (rem_done) begin
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    r_state <= S_EMULW;
                end
                S_EMULW: begin
                    if (mul_done) begin
                        if (r_k == 3'd4) begin
                            r_state <= S_EWR;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_EMUL;
                        end
                    end
                end
                S_EWR: begin
                    r_active[r_slot] <= 1'b1;
                    r_left           <= r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_FIND;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Latch request fields
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_dt     <= i_s_tdata[15:0];
            r_org[0] <= i_s_tdata[47:16];
            r_org[1] <= i_s_tdata[79:48];
            r_org[2] <= i_s_tdata[111:80];
            r_tint   <= i_s_tdata[143:112];
            r_power  <= (i_s_tdata[151:144] == 8'd0) ? 9'd1 : {1'b0, i_s_tdata[151:144]};
            r_span   <= i_s_tdata[182:152];
            r_damp   <= i_s_tdata[198:183];
        end
        // Gravity step for this tick
        if (r_state == S_GDTW && mul_done) begin
            r_gdt <= mul_res[23:0];
        end
        // Load slot, lose life and apply gravity
        if (r_state == S_LD) begin
            r_ent <= ld_ent;
        end
        // Move, then damp
        if (r_state == S_MULW && mul_done) begin
            if (r_k[0]) begin
                r_ent.vel[j_idx] <= sat32(mul_wide);
            end else begin
                r_ent.pos[j_idx] <= sat32(pos_sum);
            end
        end
        // Random draws: two angles, then the speed
        if (r_state == S_FIND && free_found) begin
            r_a1 <= draw_deg;
        end
        if (r_state == S_DRAW && r_k == 3'd0) begin
            r_a2 <= draw_deg;
        end
        if (r_state == S_REMW && rem_done) begin
            r_speed <= spd_sum[7:0];
        end
        // Spherical velocity
        if (r_state == S_EMULW && mul_done) begin
            case (r_k)
                3'd1:    r_vel[0] <= sat32(mul_wide);
                3'd3:    r_vel[2] <= sat32(mul_wide);
                3'd4:    r_vel[1] <= sat32(mul_wide);
                default: r_t <= mul_res[32:0];
            endcase
        end
        // Result payload
        if (r_state == S_OUT && out_free) begin
            r_m_last <= (r_slot == SLOT_W'(POOL_SIZE - 1));
            r_m_data <= out_word;
        end
    end

    ppi_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_slot),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ppi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_round (mul_rnd),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    ppi_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_num   (rem_num),
        .i_den   (rem_den),
        .o_done  (rem_done),
        .o_rem   (rem_out)
    );

endmodule

`default_nettype wire

// ===== src/ppi_checker.sv =====
// Port-level checker for the particle pool integrator and its bind.
`default_nettype none

module ppi_checker
    import ppi_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic [1:0]            i_s_tuser,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                  o_m_tlast
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // The last result of a tick belongs to the last slot.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[5:0] == 6'(POOL_SIZE - 1))
        else $error("tlast on a slot other than the last");

    // Inactive slots report the parked position and no color.
    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[6] |->
            o_m_tdata[38:7] == 32'd0 && o_m_tdata[70:39] == PARK_Y &&
            o_m_tdata[102:71] == 32'd0 && o_m_tdata[134:103] == 32'd0)
        else $error("inactive slot not parked");

    // A tick request keeps the block busy at least through the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == FUNC_TICK |=> !o_s_tready)
        else $error("new request taken right after a tick");

    // Reset leaves no result on the port.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind particle_pool_integrator ppi_checker u_ppi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// ===== sim/tb_particle_pool_integrator.sv =====
// Self-checking testbench for the particle pool integrator with its own slot-level predictor.
`timescale 1ns / 1ps

module tb_particle_pool_integrator;
    import ppi_pkg::*;

    // Operation code with no meaning to the block
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // One reported slot as expected on the result stream
    typedef struct {
        logic [5:0]  slot;
        logic        alive;
        logic [31:0] at_x;
        logic [31:0] at_y;
        logic [31:0] at_z;
        logic [31:0] shade;
        logic        last;
    } t_slot_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [22:0]           i_cfg_wr_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [1:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;

    particle_pool_integrator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    // Predicted pool state
    bit          pool_active [POOL_SIZE];
    int          pool_life   [POOL_SIZE];
    int          pool_pos    [POOL_SIZE][3];
    int          pool_vel    [POOL_SIZE][3];
    logic [15:0] pool_damp   [POOL_SIZE];
    logic [31:0] pool_color  [POOL_SIZE];
    logic [31:0] lfsr_state;
    logic [22:0] gravity_q16;
    int          sine_deg    [360];
    int          cosine_deg  [360];

    t_slot_report slot_reports_due[$];
    int           mismatch_count;
    bit           ready_always;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Clamp to the signed 32-bit range.
    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // Q16 product, rounded to nearest with ties away from zero.
    function automatic longint fixmul(input longint a, input longint b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r  = (ua * ub + 64'd32768) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Taylor sine of a Q2.30 angle, result in signed Q16.
    function automatic int taylor_sine(input longint ang);
        longint x;
        longint acc;
        longint term;
        bit     neg;
        int     k;
        x   = ang;
        neg = 1'b0;
        while (x >= TWOPI_Q30) x -= TWOPI_Q30;
        if (x >= PI_Q30) begin
            x -= PI_Q30;
            neg = 1'b1;
        end
        if (x > HALFPI_Q30) x = PI_Q30 - x;
        acc  = x;
        term = x;
        for (k = 1; k <= 8; k++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / ((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0) acc = 0;
        acc = (acc + 8192) >>> 14;
        return neg ? -int'(acc) : int'(acc);
    endfunction

    // Step the Galois LFSR and return the low 15 bits.
    function automatic int unsigned lfsr_draw();
        logic lsb;
        lsb        = lfsr_state[0];
        lfsr_state = {1'b0, lfsr_state[31:1]};
        if (lsb) lfsr_state = lfsr_state ^ LFSR_MASK;
        return {17'd0, lfsr_state[14:0]};
    endfunction

    // Apply one accepted request to the predicted pool.
    task automatic update_pool(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
        int unsigned  a1;
        int unsigned  a2;
        int unsigned  pw;
        longint       speed;
        longint       v;
        t_slot_report rep;
        int           i;
        int           j;
        int           n;
        int           dt;
        case (op)
            FUNC_CLEAR: begin
                for (i = 0; i < POOL_SIZE; i++) begin
                    pool_active[i] = 1'b0;
                    pool_life[i]   = 0;
                end
            end
            FUNC_EMIT: begin
                for (n = 0; n < d[205:199]; n++) begin
                    for (i = 0; i < POOL_SIZE; i++) begin
                        if (!pool_active[i]) break;
                    end
                    if (i == POOL_SIZE) break;
                    a1    = lfsr_draw() % 360;
                    a2    = lfsr_draw() % 360;
                    pw    = (d[151:144] == 8'd0) ? 1 : d[151:144];
                    speed = longint'(lfsr_draw() % pw) + 1;
                    pool_active[i] = 1'b1;
                    pool_pos[i][0] = d[47:16];
                    pool_pos[i][1] = d[79:48];
                    pool_pos[i][2] = d[111:80];
                    pool_vel[i][0] = clamp32(fixmul(speed * cosine_deg[a1], sine_deg[a2]));
                    pool_vel[i][1] = clamp32(speed * cosine_deg[a2]);
                    pool_vel[i][2] = clamp32(fixmul(speed * sine_deg[a1], sine_deg[a2]));
                    pool_color[i]  = d[143:112];
                    pool_life[i]   = int'({1'b0, d[182:152]});
                    pool_damp[i]   = d[198:183];
                end
            end
            FUNC_TICK: begin
                dt = int'({16'd0, d[15:0]});
                for (i = 0; i < POOL_SIZE; i++) begin
                    if (pool_active[i]) begin
                        if (pool_life[i] > 0) begin
                            pool_life[i]   = pool_life[i] - dt;
                            pool_vel[i][1] = clamp32(longint'(pool_vel[i][1])
                                - fixmul(longint'(gravity_q16), dt));
                            for (j = 0; j < 3; j++) begin
                                v = pool_vel[i][j];
                                pool_pos[i][j] = clamp32(longint'(pool_pos[i][j])
                                    + fixmul(v, dt));
                                pool_vel[i][j] = clamp32(fixmul(v, longint'(pool_damp[i])));
                            end
                        end else begin
                            pool_active[i] = 1'b0;
                        end
                    end
                    rep.slot  = i[5:0];
                    rep.alive = pool_active[i];
                    rep.at_x  = pool_active[i] ? pool_pos[i][0] : 32'd0;
                    rep.at_y  = pool_active[i] ? pool_pos[i][1] : PARK_Y;
                    rep.at_z  = pool_active[i] ? pool_pos[i][2] : 32'd0;
                    rep.shade = pool_active[i] ? pool_color[i] : 32'd0;
                    rep.last  = (i == POOL_SIZE - 1);
                    slot_reports_due = {slot_reports_due, rep};
                end
            end
            default: begin
                // Unused code: nothing happens.
            end
        endcase
    endtask

    // Print one mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare each delivered slot report with the oldest one due.
    always @(posedge i_clk) begin
        t_slot_report exp_rep;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (slot_reports_due.size() == 0) begin
                report_mismatch("unexpected report", o_m_tdata[31:0], 32'd0);
            end else begin
                exp_rep = slot_reports_due.pop_front();
                if (o_m_tdata[5:0] !== exp_rep.slot)
                    report_mismatch("slot", 32'(o_m_tdata[5:0]), 32'(exp_rep.slot));
                if (o_m_tdata[6] !== exp_rep.alive)
                    report_mismatch("alive", 32'(o_m_tdata[6]), 32'(exp_rep.alive));
                if (o_m_tdata[38:7] !== exp_rep.at_x)
                    report_mismatch("at_x", o_m_tdata[38:7], exp_rep.at_x);
                if (o_m_tdata[70:39] !== exp_rep.at_y)
                    report_mismatch("at_y", o_m_tdata[70:39], exp_rep.at_y);
                if (o_m_tdata[102:71] !== exp_rep.at_z)
                    report_mismatch("at_z", o_m_tdata[102:71], exp_rep.at_z);
                if (o_m_tdata[134:103] !== exp_rep.shade)
                    report_mismatch("shade", o_m_tdata[134:103], exp_rep.shade);
                if (o_m_tlast !== exp_rep.last)
                    report_mismatch("last", 32'(o_m_tlast), 32'(exp_rep.last));
            end
        end
    end

    // Result-side back-pressure: bursts of ready, short stalls and a few long ones.
    initial begin
        int run_len;
        int stall_len;
        i_m_tready = 1'b0;
        forever begin
            run_len = $urandom_range(1, 40);
            repeat (run_len) begin
                @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
            if (!ready_always) begin
                stall_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 3);
                repeat (stall_len) begin
                    @(posedge i_clk);
                    i_m_tready <= 1'b0;
                end
            end
        end
    end

    // Pack the request payload, first field in the lowest bits.
    function automatic logic [IN_DATA_W-1:0] pack_req(
        input logic [15:0] dt, input logic [31:0] ox, input logic [31:0] oy,
        input logic [31:0] oz, input logic [31:0] tint, input logic [7:0] power,
        input logic [30:0] life, input logic [15:0] damp, input logic [6:0] count);
        return {2'b00, count, damp, life, power, tint, oz, oy, ox, dt};
    endfunction

    // Send one request after a random gap, then fold it into the predictor.
    task automatic send_req(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        gap  = (pick < 45) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        update_pool(op, d);
    endtask

    // Stop sending and wait until the block has gone quiet.
    task automatic drain_pool();
        i_s_tvalid <= 1'b0;
        while (slot_reports_due.size() != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
    endtask

    // Write the gravity register while the block is idle.
    task automatic write_gravity(input logic [22:0] g);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        gravity_q16 = g;
    endtask

    function automatic logic [IN_DATA_W-1:0] tick_req(input logic [15:0] dt);
        return pack_req(dt, 0, 0, 0, 0, 0, 0, 0, 0);
    endfunction

    // Tick on an empty pool, a tiny burst at zero power, and the unused code.
    task automatic test_basics();
        send_req(FUNC_TICK, tick_req(16'd0));
        send_req(FUNC_EMIT, pack_req(0, 0, 0, 0, 32'hFFFFFFFF, 8'd0, 31'd100000,
                                     16'hFFFF, 7'd0));
        send_req(FUNC_EMIT, pack_req(0, 32'h0001_0000, 32'hFFFF_0000, 0, 32'hA5A5A5A5,
                                     8'd0, 31'd100000, 16'hFFFF, 7'd3));
        send_req(FUNC_TICK, tick_req(16'd655));
        send_req(FUNC_NONE, pack_req(16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 7'd64));
        send_req(FUNC_TICK, tick_req(16'hFFFF));
        drain_pool();
    endtask

    // Full pool, extreme origins, zero life and the widest fields.
    task automatic test_extremes();
        send_req(FUNC_CLEAR, tick_req(0));
        send_req(FUNC_EMIT, pack_req(0, 32'h7FFFFFF0, 32'h80000010, 32'h7FFFFFFF,
                                     32'h12345678, 8'd255, 31'h7FFFFFFF, 16'hFFFF, 7'd40));
        send_req(FUNC_EMIT, pack_req(0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                     32'h5A5A5A5A, 8'd128, 31'd0, 16'd0, 7'd64));
        send_req(FUNC_EMIT, pack_req(0, 0, 0, 0, 32'h0, 8'd1, 31'd5, 16'h8000, 7'd64));
        send_req(FUNC_TICK, tick_req(16'hFFFF));
        send_req(FUNC_TICK, tick_req(16'h8000));
        send_req(FUNC_TICK, tick_req(16'd1));
        drain_pool();
    endtask

    // Gravity at its extremes on a live pool.
    task automatic test_gravity();
        write_gravity(23'd0);
        send_req(FUNC_CLEAR, tick_req(0));
        send_req(FUNC_EMIT, pack_req(0, 0, 0, 0, 32'hCAFE0001, 8'd200, 31'h00100000,
                                     16'hFAFA, 7'd10));
        send_req(FUNC_TICK, tick_req(16'd3000));
        drain_pool();
        write_gravity(23'd4194304);
        send_req(FUNC_TICK, tick_req(16'hFFFF));
        send_req(FUNC_TICK, tick_req(16'hFFFF));
        drain_pool();
        write_gravity(GRAVITY_RESET);
    endtask

    // Mostly emit and tick traffic with random content, a few clears and unused codes.
    task automatic test_random(input int count);
        int          k;
        int          pick;
        logic [31:0] org [3];
        logic [6:0]  burst;
        logic [30:0] life;
        logic [15:0] damp;
        logic [15:0] dt;
        for (k = 0; k < count; k++) begin
            if (k == count / 3) begin
                drain_pool();
                write_gravity(23'($urandom_range(0, 4194304)));
                ready_always = 1'b1;
            end else if (k == 2 * count / 3) begin
                drain_pool();
                write_gravity(23'd4194304);
                ready_always = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                dt = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 6554));
                send_req(FUNC_TICK, tick_req(dt));
            end else if (pick < 90) begin
                foreach (org[j])
                    org[j] = ($urandom_range(0, 4) == 0) ? $urandom()
                                                         : $urandom_range(0, 2000000) - 1000000;
                pick  = $urandom_range(0, 99);
                burst = 7'((pick < 85) ? $urandom_range(0, 6) :
                           (pick < 95) ? $urandom_range(7, 20) : 64);
                life  = 31'(($urandom_range(0, 9) == 0) ? $urandom()
                                                        : $urandom_range(0, 400000));
                damp  = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(16'hF000, 16'hFFFF));
                send_req(FUNC_EMIT, pack_req(0, org[0], org[1], org[2], $urandom(),
                                             8'($urandom_range(0, 255)), life, damp, burst));
            end else if (pick < 95) begin
                send_req(FUNC_CLEAR, pack_req(16'($urandom()), $urandom(), 0, 0, 0, 0, 0, 0,
                                              0));
            end else begin
                send_req(FUNC_NONE, pack_req(16'($urandom()), $urandom(), $urandom(),
                                             $urandom(), $urandom(), 8'($urandom()),
                                             31'($urandom()), 16'($urandom()),
                                             7'($urandom())));
            end
        end
        send_req(FUNC_TICK, tick_req(16'($urandom_range(0, 6554))));
        i_s_tvalid <= 1'b0;
    endtask

    // Sequence of tests
    initial begin
        int d;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = FUNC_TICK;
        mismatch_count = 0;
        ready_always   = 1'b0;
        for (d = 0; d < 360; d++) begin
            sine_deg[d]   = taylor_sine((longint'(d) * 157 <<< 30) / 9000);
            cosine_deg[d] = taylor_sine(((longint'(d) * 157 <<< 30) / 9000) + HALFPI_Q30);
        end
        for (d = 0; d < POOL_SIZE; d++) begin
            pool_active[d] = 1'b0;
            pool_life[d]   = 0;
        end
        lfsr_state  = SEED_INIT;
        gravity_q16 = GRAVITY_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basics();
        test_extremes();
        test_gravity();
        test_random(390);

        while (slot_reports_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
